// ----- design/twbc_pkg.sv -----
// twbc_pkg: shared constants and codes for the two-level write-back cache core
// used by two_level_write_back_cache_core and its testbench, no dependencies
package twbc_pkg;

  // access modes carried on in_tuser
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_L1_RD  = 3'd0;
  localparam logic [2:0] CFG_L1_WR  = 3'd1;
  localparam logic [2:0] CFG_L2_RD  = 3'd2;
  localparam logic [2:0] CFG_L2_WR  = 3'd3;
  localparam logic [2:0] CFG_MEM_RD = 3'd4;
  localparam logic [2:0] CFG_MEM_WR = 3'd5;

  // field widths
  localparam int ADDR_W = 16;
  localparam int WORD_W = 32;
  localparam int LAT_W  = 10;
  localparam int COST_W = 13;

  typedef logic [LAT_W-1:0] lat_t;

endpackage

// ----- design/twbc_ram.sv -----
// twbc_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module twbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/two_level_write_back_cache_core.sv -----
// two_level_write_back_cache_core: direct-mapped write-back L1 and L2 over a
// zero-cleared backing memory, with an access time counter
// depends on twbc_pkg and twbc_ram
//
// Input words arrive on in_tvalid/in_tready: in_tuser holds the mode (read,
// write, clear counter), in_tdata the byte address and write data. Each word
// gives exactly one result word on out_tvalid/out_tready with the read data,
// the cost of this access and the running time total.
// Costs are to be set through the cfg_ channel while no access is in flight;
// the core does not enforce this. One access at a time runs through a
// sequencer that reads, checks and writes the tag and data rams of each
// level: an L1 hit goes from the L1 read to its check and the word step, an
// L1 miss reads and checks L2 and, on an L2 miss, reads memory, and a dirty
// L1 victim is then written back into L2 through the same L2 steps. Clear
// and unused modes go straight to the word step. A new word is taken only once
// the result sits in the output register; the next word is accepted while it
// waits, and a stalled receiver holds the sequencer only at its last step.
// After reset the backing memory is swept to zero, one block per cycle, over
// all 2^(address bits - block offset bits) blocks (4096 with the defaults);
// in_tready stays low during that sweep, cfg writes are still taken.
module two_level_write_back_cache_core #(
  parameter int WORD_BYTES  = 4,
  parameter int BLOCK_BYTES = 16,
  parameter int L1_LINES    = 16,
  parameter int L2_LINES    = 64,
  parameter int MEM_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic [47:0] in_tdata,   // byte_address[15:0], write_data[47:16]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // read_data[31:0], access_cost[44:32],
                                  // total_time[76:45], zero fill above
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int OFFW = $clog2(BLOCK_BYTES);
  localparam int MAW  = $clog2(MEM_BYTES);
  localparam int EAW  = (MAW < twbc_pkg::ADDR_W) ? MAW : twbc_pkg::ADDR_W;
  localparam int BNW  = EAW - OFFW;
  localparam int L1W  = $clog2(L1_LINES);
  localparam int L2W  = $clog2(L2_LINES);
  localparam int T1W  = BNW - L1W;
  localparam int T2W  = BNW - L2W;
  localparam int BLKW = BLOCK_BYTES * 8;
  localparam int MEMD = 1 << BNW;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_L1REQ = 4'd2;
  localparam logic [3:0] S_L1CHK = 4'd3;
  localparam logic [3:0] S_L2REQ = 4'd4;
  localparam logic [3:0] S_L2CHK = 4'd5;
  localparam logic [3:0] S_MEMRD = 4'd6;
  localparam logic [3:0] S_L2OP  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r;

  // configuration registers
  twbc_pkg::lat_t l1_rd_r, l1_wr_r, l2_rd_r, l2_wr_r, mem_rd_r, mem_wr_r;

  // access registers
  logic [1:0]                    mode_r;
  logic [twbc_pkg::ADDR_W-1:0]   addr_r;
  logic [twbc_pkg::WORD_W-1:0]   data_r;
  logic [twbc_pkg::COST_W-1:0]   cost_r;
  logic [twbc_pkg::WORD_W-1:0]   time_r;
  logic [BNW-1:0]                clr_r;

  logic [BLKW-1:0] blk_r, vic1_r, vic2_r, line_r;
  logic [T1W-1:0]  vtag1_r;
  logic [T2W-1:0]  vtag2_r;
  logic            vic1wb_r, vic2wb_r, fill1_r, fill2_r, wb_r;
  logic [BNW-1:0]  l2blk_r;

  logic [L1_LINES-1:0] v1_r;
  logic [L2_LINES-1:0] v2_r;

  // output register
  logic        out_tvalid_r;
  logic [79:0] out_tdata_r;

  // address fields
  logic [BNW-1:0]  blk;
  logic [L1W-1:0]  i1;
  logic [T1W-1:0]  t1;
  logic [L2W-1:0]  i2;
  logic [T2W-1:0]  t2;
  logic [OFFW-1:0] boff, woff;

  assign blk  = addr_r[EAW-1:OFFW];
  assign i1   = blk[L1W-1:0];
  assign t1   = blk[BNW-1:L1W];
  assign i2   = l2blk_r[L2W-1:0];
  assign t2   = l2blk_r[BNW-1:L2W];
  assign boff = addr_r[OFFW-1:0];
  assign woff = OFFW'((int'(boff) / WORD_BYTES) * WORD_BYTES);

  // ram ports
  logic            l1d_we, l1m_we, l2d_we, l2m_we, mem_we;
  logic [BLKW-1:0] l1d_wdata, l2d_wdata, mem_wdata;
  logic [T1W:0]    l1m_wdata, l1m_rdata;
  logic [T2W:0]    l2m_wdata, l2m_rdata;
  logic [BLKW-1:0] l1d_rdata, l2d_rdata, mem_rdata;
  logic [BNW-1:0]  mem_waddr;

  twbc_ram #(.WIDTH(BLKW), .DEPTH(L1_LINES)) u_l1_data (
    .clk(clk), .we(l1d_we), .waddr(i1), .wdata(l1d_wdata),
    .raddr(i1), .rdata(l1d_rdata));
  twbc_ram #(.WIDTH(T1W+1), .DEPTH(L1_LINES)) u_l1_meta (
    .clk(clk), .we(l1m_we), .waddr(i1), .wdata(l1m_wdata),
    .raddr(i1), .rdata(l1m_rdata));
  twbc_ram #(.WIDTH(BLKW), .DEPTH(L2_LINES)) u_l2_data (
    .clk(clk), .we(l2d_we), .waddr(i2), .wdata(l2d_wdata),
    .raddr(i2), .rdata(l2d_rdata));
  twbc_ram #(.WIDTH(T2W+1), .DEPTH(L2_LINES)) u_l2_meta (
    .clk(clk), .we(l2m_we), .waddr(i2), .wdata(l2m_wdata),
    .raddr(i2), .rdata(l2m_rdata));
  twbc_ram #(.WIDTH(BLKW), .DEPTH(MEMD)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(l2blk_r), .rdata(mem_rdata));

  // hit checks
  logic l1_hit, l2_hit, slot_free, is_wr;
  assign l1_hit    = v1_r[i1] && (l1m_rdata[T1W-1:0] == t1);
  assign l2_hit    = v2_r[i2] && (l2m_rdata[T2W-1:0] == t2);
  assign slot_free = !out_tvalid_r || out_tready;
  assign is_wr     = (mode_r == twbc_pkg::MODE_STORE);

  // word merge and word extract on the held line
  logic [BLKW-1:0]             merged;
  logic [twbc_pkg::WORD_W-1:0] rd_word;
  always_comb begin
    int k;
    merged  = blk_r;
    rd_word = '0;
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      k = j - int'(woff);
      if (k >= 0 && k < WORD_BYTES) begin
        merged[8*j +: 8] = (k < 4) ? 8'(data_r >> (8 * k)) : 8'd0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (i < WORD_BYTES && int'(woff) + i < BLOCK_BYTES) begin
        rd_word[8*i +: 8] = 8'(blk_r >> (8 * (int'(woff) + i)));
      end
    end
  end

  // final cost of a word access
  logic [twbc_pkg::COST_W-1:0] cost_fin;
  assign cost_fin = cost_r + twbc_pkg::COST_W'(is_wr ? l1_wr_r : l1_rd_r);

  // ram write controls
  always_comb begin
    l1d_we    = 1'b0;
    l1m_we    = 1'b0;
    l1d_wdata = is_wr ? merged : blk_r;
    l1m_wdata = {is_wr, t1};
    l2d_we    = 1'b0;
    l2m_we    = 1'b0;
    l2d_wdata = wb_r ? vic1_r : line_r;
    l2m_wdata = {wb_r, t2};
    mem_we    = 1'b0;
    mem_waddr = {vtag2_r, i2};
    mem_wdata = vic2_r;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_MEMRD: begin
        mem_we = vic2wb_r;
      end
      S_L2OP: begin
        l2d_we = wb_r || fill2_r;
        l2m_we = wb_r || fill2_r;
      end
      S_FIN: begin
        if (mode_r == twbc_pkg::MODE_LOAD || is_wr) begin
          l1d_we = slot_free && (is_wr || fill1_r);
          l1m_we = slot_free && (is_wr || fill1_r);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      v1_r         <= '0;
      v2_r         <= '0;
      time_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result taken and no new one replacing it
      if (out_tvalid_r && out_tready && !(state_r == S_FIN && slot_free)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            addr_r  <= in_tdata[15:0];
            data_r  <= in_tdata[47:16];
            cost_r  <= '0;
            state_r <= (in_tuser[1] == 1'b0) ? S_L1REQ : S_FIN;
          end
        end
        S_L1REQ: state_r <= S_L1CHK;
        S_L1CHK: begin
          blk_r    <= l1d_rdata;
          vic1_r   <= l1d_rdata;
          vtag1_r  <= l1m_rdata[T1W-1:0];
          vic1wb_r <= v1_r[i1] && l1m_rdata[T1W];
          fill1_r  <= !l1_hit;
          l2blk_r  <= blk;
          wb_r     <= 1'b0;
          state_r  <= l1_hit ? S_FIN : S_L2REQ;
        end
        S_L2REQ: state_r <= S_L2CHK;
        S_L2CHK: begin
          line_r   <= l2d_rdata;
          vic2_r   <= l2d_rdata;
          vtag2_r  <= l2m_rdata[T2W-1:0];
          vic2wb_r <= v2_r[i2] && l2m_rdata[T2W];
          fill2_r  <= 1'b0;
          state_r  <= l2_hit ? S_L2OP : S_MEMRD;
        end
        S_MEMRD: begin
          line_r  <= mem_rdata;
          fill2_r <= 1'b1;
          cost_r  <= cost_r + twbc_pkg::COST_W'(mem_rd_r)
                     + (vic2wb_r ? twbc_pkg::COST_W'(mem_wr_r) : '0);
          state_r <= S_L2OP;
        end
        S_L2OP: begin
          v2_r[i2] <= 1'b1;
          cost_r   <= cost_r + twbc_pkg::COST_W'(wb_r ? l2_wr_r : l2_rd_r);
          if (!wb_r) begin
            blk_r <= line_r;
          end
          if (!wb_r && vic1wb_r) begin
            wb_r    <= 1'b1;
            l2blk_r <= {vtag1_r, i1};
            state_r <= S_L2REQ;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
            if (mode_r == twbc_pkg::MODE_CLEAR) begin
              time_r      <= '0;
              out_tdata_r <= '0;
            end else if (mode_r[1]) begin
              out_tdata_r <= {3'd0, time_r, 13'd0, 32'd0};
            end else begin
              v1_r[i1]    <= 1'b1;
              time_r      <= time_r + 32'(cost_fin);
              out_tdata_r <= {3'd0, time_r + 32'(cost_fin), cost_fin,
                              is_wr ? 32'd0 : rd_word};
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_rd_r  <= 10'd1;
      l1_wr_r  <= 10'd1;
      l2_rd_r  <= 10'd10;
      l2_wr_r  <= 10'd10;
      mem_rd_r <= 10'd100;
      mem_wr_r <= 10'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        twbc_pkg::CFG_L1_RD:  l1_rd_r  <= cfg_data;
        twbc_pkg::CFG_L1_WR:  l1_wr_r  <= cfg_data;
        twbc_pkg::CFG_L2_RD:  l2_rd_r  <= cfg_data;
        twbc_pkg::CFG_L2_WR:  l2_wr_r  <= cfg_data;
        twbc_pkg::CFG_MEM_RD: mem_rd_r <= cfg_data;
        twbc_pkg::CFG_MEM_WR: mem_wr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an L1 hit goes straight to the word step
  a_hit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L1CHK && l1_hit) |=> (state_r == S_FIN))
    else $error("l1 hit did not finish");

  // after an L2 transfer either the victim write-back starts or the access ends
  a_l2op_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L2OP) |=> (state_r == S_L2REQ || state_r == S_FIN))
    else $error("bad step after l2 transfer");

  // a counter clear leaves the counter at zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && mode_r == twbc_pkg::MODE_CLEAR && slot_free)
    |=> (time_r == 32'd0))
    else $error("time counter not cleared");

endmodule

// ----- test/tb_two_level_write_back_cache_core.sv -----
// tb_two_level_write_back_cache_core: random and directed accesses against a
// behavioural two-level cache predictor with per-field result checks
// depends on twbc_pkg and two_level_write_back_cache_core
`timescale 1ns / 1ps

module tb_two_level_write_back_cache_core;

  localparam int L1N = 16;
  localparam int L2N = 64;
  localparam int MEMB = 4096;
  localparam int LIMIT = 3000000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [12:0] cost;
    logic [31:0] total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  two_level_write_back_cache_core dut (.*);

  always #5 clk = ~clk;

  // predictor state
  twbc_pkg::lat_t cost_l1r, cost_l1w, cost_l2r, cost_l2w, cost_mr, cost_mw;
  logic l1v [L1N];
  logic l1d [L1N];
  logic [7:0] l1t [L1N];
  logic [127:0] l1b [L1N];
  logic l2v [L2N];
  logic l2d [L2N];
  logic [5:0] l2t [L2N];
  logic [127:0] l2b [L2N];
  logic [127:0] mem_blk [MEMB];
  logic [31:0] clock_total;
  logic [31:0] run_cost;

  access_t pending_words[$];
  result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  logic hold_off;
  int send_gap = 0;
  int recv_gap = 0;

  // l2 block transfer, fetching from memory on a miss
  function automatic void l2_transfer(input logic [11:0] blk, inout logic [127:0] buf_q,
                                      input bit wr);
    logic [5:0] idx;
    logic [5:0] tg;
    logic [127:0] fresh;
    idx = blk[5:0];
    tg = blk[11:6];
    if (!l2v[idx] || l2t[idx] != tg) begin
      fresh = mem_blk[blk];
      run_cost += 32'(cost_mr);
      if (l2v[idx] && l2d[idx]) begin
        mem_blk[{l2t[idx], idx}] = l2b[idx];
        run_cost += 32'(cost_mw);
      end
      l2b[idx] = fresh;
      l2v[idx] = 1'b1;
      l2t[idx] = tg;
      l2d[idx] = 1'b0;
    end
    if (wr) begin
      l2b[idx] = buf_q;
      run_cost += 32'(cost_l2w);
      l2d[idx] = 1'b1;
    end else begin
      buf_q = l2b[idx];
      run_cost += 32'(cost_l2r);
    end
  endfunction

  function automatic result_t predict_access(input access_t a);
    result_t r;
    logic [11:0] blk;
    logic [3:0] idx;
    logic [7:0] tg;
    logic [1:0] wsel;
    logic [127:0] fresh;
    logic [127:0] victim;
    blk = a.addr[15:4];
    idx = blk[3:0];
    tg = blk[11:4];
    wsel = a.addr[3:2];
    run_cost = '0;
    r.rdata = '0;
    if (a.mode == twbc_pkg::MODE_CLEAR) begin
      clock_total = '0;
    end else if (a.mode == twbc_pkg::MODE_LOAD || a.mode == twbc_pkg::MODE_STORE) begin
      if (!l1v[idx] || l1t[idx] != tg) begin
        fresh = '0;
        l2_transfer(blk, fresh, 1'b0);
        if (l1v[idx] && l1d[idx]) begin
          victim = l1b[idx];
          l2_transfer({l1t[idx], idx}, victim, 1'b1);
        end
        l1b[idx] = fresh;
        l1v[idx] = 1'b1;
        l1t[idx] = tg;
        l1d[idx] = 1'b0;
      end
      if (a.mode == twbc_pkg::MODE_LOAD) begin
        r.rdata = l1b[idx][wsel*32 +: 32];
        run_cost += 32'(cost_l1r);
      end else begin
        l1b[idx][wsel*32 +: 32] = a.wdata;
        run_cost += 32'(cost_l1w);
        l1d[idx] = 1'b1;
      end
      clock_total += run_cost;
    end
    r.cost = run_cost[12:0];
    r.total = clock_total;
    return r;
  endfunction

  // driver: one word at a time from the pending queue, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_access(pending_words.pop_front()));
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        in_tvalid <= 1'b0;
      end else if (!in_tvalid && pending_words.size() > 0) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_words[0].mode;
          in_tdata <= {pending_words[0].wdata, pending_words[0].addr};
        end
      end
    end
  end

  // long receiver hold-off, counted apart from the monitor
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      if (hold_count == HOLD_LEN - 1) begin
        hold_done <= 1'b1;
      end
      hold_count <= hold_count + 1;
    end
  end

  assign hold_off = hold_start && !hold_done;

  // monitor: random stalls, long hold-off when requested
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.rdata = out_tdata[31:0];
        got.cost = out_tdata[44:32];
        got.total = out_tdata[76:45];
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
            errors++;
          end
          if (got.cost !== want.cost) begin
            $display("%0t: access_cost expected %0d actual %0d", $time, want.cost, got.cost);
            errors++;
          end
          if (got.total !== want.total) begin
            $display("%0t: total_time expected %0d actual %0d", $time, want.total, got.total);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_two_level_write_back_cache_core: errors");
      $finish;
    end
  end

  // one register write, valid left high for the caller to drop
  task automatic write_cost(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      twbc_pkg::CFG_L1_RD:  cost_l1r = val;
      twbc_pkg::CFG_L1_WR:  cost_l1w = val;
      twbc_pkg::CFG_L2_RD:  cost_l2r = val;
      twbc_pkg::CFG_L2_WR:  cost_l2w = val;
      twbc_pkg::CFG_MEM_RD: cost_mr = val;
      twbc_pkg::CFG_MEM_WR: cost_mw = val;
      default: ;
    endcase
  endtask

  task automatic set_costs(input logic [9:0] a, b, c, d, e, f);
    write_cost(twbc_pkg::CFG_L1_RD, a);
    write_cost(twbc_pkg::CFG_L1_WR, b);
    write_cost(twbc_pkg::CFG_L2_RD, c);
    write_cost(twbc_pkg::CFG_L2_WR, d);
    write_cost(twbc_pkg::CFG_MEM_RD, e);
    write_cost(twbc_pkg::CFG_MEM_WR, f);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input logic [1:0] m, input logic [15:0] a, input logic [31:0] d);
    access_t w;
    w.mode = m;
    w.addr = a;
    w.wdata = d;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly local traffic that keeps conflicting in both levels
  task automatic random_burst(input int n);
    logic [15:0] a;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70)
        a = {$urandom_range(0, 7) == 0 ? 4'($urandom) : 4'($urandom_range(0, 1)),
             2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 2'($urandom)};
      else
        a = 16'($urandom);
      k = $urandom_range(0, 99);
      queue_word(k < 45 ? twbc_pkg::MODE_LOAD : k < 90 ? twbc_pkg::MODE_STORE :
                 k < 95 ? twbc_pkg::MODE_CLEAR : twbc_pkg::MODE_NONE,
                 a, $urandom);
    end
  endtask

  initial begin
    cost_l1r = 10'd1; cost_l1w = 10'd1; cost_l2r = 10'd10; cost_l2w = 10'd10;
    cost_mr = 10'd100; cost_mw = 10'd100;
    for (int i = 0; i < L1N; i++) begin
      l1v[i] = 1'b0; l1d[i] = 1'b0; l1t[i] = '0; l1b[i] = '0;
    end
    for (int i = 0; i < L2N; i++) begin
      l2v[i] = 1'b0; l2d[i] = 1'b0; l2t[i] = '0; l2b[i] = '0;
    end
    for (int i = 0; i < MEMB; i++) mem_blk[i] = '0;
    clock_total = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset costs, edges of fields, all modes, victim chains
    queue_word(twbc_pkg::MODE_LOAD, 16'h0000, 32'h0);
    queue_word(twbc_pkg::MODE_STORE, 16'h0004, 32'hFFFF_FFFF);
    queue_word(twbc_pkg::MODE_LOAD, 16'h0007, 32'hFFFF_FFFF);
    queue_word(twbc_pkg::MODE_STORE, 16'hFFFF, 32'hA5A5_5A5A);
    queue_word(twbc_pkg::MODE_LOAD, 16'hFFFC, 32'h0);
    queue_word(twbc_pkg::MODE_STORE, 16'h0100, 32'h1234_5678);
    queue_word(twbc_pkg::MODE_LOAD, 16'h0000, 32'h0);
    queue_word(twbc_pkg::MODE_STORE, 16'h0400, 32'h8765_4321);
    queue_word(twbc_pkg::MODE_LOAD, 16'h0100, 32'h0);
    queue_word(twbc_pkg::MODE_LOAD, 16'h0004, 32'h0);
    queue_word(twbc_pkg::MODE_NONE, 16'h1234, 32'hDEAD_BEEF);
    queue_word(twbc_pkg::MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(twbc_pkg::MODE_LOAD, 16'h8000, 32'h0);
    queue_word(twbc_pkg::MODE_LOAD, 16'hFFFF, 32'h0);
    wait_drained();

    // extremes of every cost
    set_costs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    random_burst(30);
    wait_drained();
    set_costs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    random_burst(20);
    wait_drained();

    // long receiver hold-off while the sender keeps going
    set_costs(10'd3, 10'd5, 10'd17, 10'd29, 10'd211, 10'd307);
    hold_start = 1'b1;
    random_burst(400);
    wait_drained();

    set_costs(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
              10'($urandom), 10'($urandom));
    random_burst(380);
    wait_drained();

    $display("covered %0d accesses under five cost settings, with idle gaps and a long stall",
             results_seen);
    if (errors == 0)
      $display("tb_two_level_write_back_cache_core: clean");
    else
      $display("tb_two_level_write_back_cache_core: errors");
    $finish;
  end

endmodule
